// ----- rtl/lvf_pkg.sv -----
package lvf_pkg;

  // field widths
  localparam int FREQ_W  = 26;
  localparam int OHMS_W  = 13;
  localparam int WORD_W  = 10;
  localparam int BIN_W   = 14;
  localparam int BCD_W   = 16;
  localparam int CNT_W   = $clog2(BIN_W);

  // word codes and limits
  localparam logic [OHMS_W-1:0] OHMS_MAX   = 13'd5000;
  localparam logic [WORD_W-1:0] LINE1_ADDR = 10'h080;
  localparam logic [WORD_W-1:0] LINE2_ADDR = 10'h0C0;
  localparam logic [WORD_W-1:0] DATA_BIT   = 10'h200;
  localparam logic [WORD_W-1:0] ASCII_ZERO = 10'h030;
  localparam logic [WORD_W-1:0] CLEAR_WORD = 10'h001;
  localparam logic [4:0]        REDRAW_END = 5'd16;

  // request to the shared binary to bcd unit
  typedef struct packed {
    logic             start;
    logic [BIN_W-1:0] value;
  } bcd_req_t;

  // response of the shared binary to bcd unit
  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] digits;
  } bcd_rsp_t;

  // one instruction word from the sequencer
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
    logic              last;
  } emit_t;

  // fixed label sequence, each character after its address word
  function automatic logic [WORD_W-1:0] label_word(input logic [3:0] idx);
    logic [WORD_W-1:0] w;
    case (idx)
      4'd0:    w = 10'h080;
      4'd1:    w = 10'h246;
      4'd2:    w = 10'h081;
      4'd3:    w = 10'h23A;
      4'd4:    w = 10'h086;
      4'd5:    w = 10'h248;
      4'd6:    w = 10'h087;
      4'd7:    w = 10'h27A;
      4'd8:    w = 10'h0C0;
      4'd9:    w = 10'h252;
      4'd10:   w = 10'h0C1;
      4'd11:   w = 10'h23A;
      4'd12:   w = 10'h0C6;
      4'd13:   w = 10'h24F;
      4'd14:   w = 10'h0C7;
      default: w = 10'h268;
    endcase
    return w;
  endfunction

  // clear word first, then the label sequence
  function automatic logic [WORD_W-1:0] redraw_word(input logic [4:0] idx);
    logic [WORD_W-1:0] w;
    logic [3:0]        li;
    li = 4'(idx - 5'd1);
    if (idx == 5'd0) begin
      w = CLEAR_WORD;
    end else begin
      w = label_word(li);
    end
    return w;
  endfunction

  // number of significant digits in a four digit bcd word
  function automatic logic [2:0] digit_count(input logic [BCD_W-1:0] d);
    logic [2:0] c;
    if (d[15:12] != 4'd0) begin
      c = 3'd4;
    end else if (d[11:8] != 4'd0) begin
      c = 3'd3;
    end else if (d[7:4] != 4'd0) begin
      c = 3'd2;
    end else begin
      c = 3'd1;
    end
    return c;
  endfunction

  // index of the last word of a digit field
  function automatic logic [2:0] digit_end(input logic [2:0] nd);
    return 3'((4'(nd) << 1) - 4'd1);
  endfunction

  // address or character word of a right-aligned digit field
  function automatic logic [WORD_W-1:0] digit_word(input logic [WORD_W-1:0] line,
                                                   input logic [2:0]        nd,
                                                   input logic [BCD_W-1:0]  d,
                                                   input logic [2:0]        idx);
    logic [1:0]        k;
    logic [1:0]        sel;
    logic [2:0]        col;
    logic [3:0]        nib;
    logic [WORD_W-1:0] w;
    k   = idx[2:1];
    sel = 2'(nd - 3'd1 - {1'b0, k});
    col = 3'(3'd6 - nd + {1'b0, k});
    case (sel)
      2'd0:    nib = d[3:0];
      2'd1:    nib = d[7:4];
      2'd2:    nib = d[11:8];
      default: nib = d[15:12];
    endcase
    if (!idx[0]) begin
      w = line + {7'd0, col};
    end else begin
      w = DATA_BIT | ASCII_ZERO | {6'd0, nib};
    end
    return w;
  endfunction

endpackage

// ----- rtl/lvf_bcd.sv -----
module lvf_bcd import lvf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  bcd_req_t req,
  output bcd_rsp_t rsp
);

  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [BCD_W-1:0] adj;

  // add three to every nibble of five or more
  always_comb begin
    for (int i = 0; i < BCD_W / 4; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  // one shift-and-adjust step per cycle
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      bcd_nxt = {adj[BCD_W-2:0], bin_r[BIN_W-1]};
      bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(BIN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      bin_nxt  = req.value;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.digits = bcd_r;

endmodule

// ----- rtl/lvf_ctrl.sv -----
module lvf_ctrl import lvf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FREQ_W-1:0] freq_value,
  input  logic [OHMS_W-1:0] ohms_value,
  output bcd_req_t          req,
  input  bcd_rsp_t          rsp,
  output emit_t             emit,
  input  logic              emit_ready
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FCONV = 7'b0000010,
    ST_OCONV = 7'b0000100,
    ST_FRED  = 7'b0001000,
    ST_FDIG  = 7'b0010000,
    ST_RRED  = 7'b0100000,
    ST_RDIG  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        fprev_r, fprev_nxt;
  logic [2:0]        rprev_r, rprev_nxt;
  logic [2:0]        fnd_r, fnd_nxt;
  logic [2:0]        rnd_r, rnd_nxt;
  logic              fshow_r, fshow_nxt;
  logic              fred_r, fred_nxt;
  logic              rred_r, rred_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [OHMS_W-1:0] ohms_r, ohms_nxt;
  logic [BCD_W-1:0]  fdig_r, fdig_nxt;
  logic [BCD_W-1:0]  odig_r, odig_nxt;

  logic              freq_ok;
  logic              freq_four;
  logic [OHMS_W-1:0] ohms_sat;
  logic [2:0]        rsp_count;

  assign freq_ok   = (freq_value >= 26'd100) && (freq_value < 26'd10000);
  assign freq_four = freq_value >= 26'd1000;
  assign ohms_sat  = (ohms_value > OHMS_MAX) ? OHMS_MAX : ohms_value;
  assign rsp_count = digit_count(rsp.digits);
  assign in_ready  = (state_r == ST_IDLE);

  // sequencer: a frequency conversion when it is in range, a resistance conversion, then the word phases
  always_comb begin
    state_nxt  = state_r;
    fprev_nxt  = fprev_r;
    rprev_nxt  = rprev_r;
    fnd_nxt    = fnd_r;
    rnd_nxt    = rnd_r;
    fshow_nxt  = fshow_r;
    fred_nxt   = fred_r;
    rred_nxt   = rred_r;
    cnt_nxt    = cnt_r;
    ohms_nxt   = ohms_r;
    fdig_nxt   = fdig_r;
    odig_nxt   = odig_r;
    req.start  = 1'b0;
    req.value  = {1'b0, ohms_r};
    emit.valid = 1'b0;
    emit.word  = redraw_word(cnt_r);
    emit.last  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ohms_nxt = ohms_sat;
          req.start = 1'b1;
          if (freq_ok) begin
            req.value = freq_value[BIN_W-1:0];
            fnd_nxt   = freq_four ? 3'd4 : 3'd3;
            fred_nxt  = !freq_four && (fprev_r != 3'd3);
            fprev_nxt = freq_four ? 3'd4 : 3'd3;
            fshow_nxt = 1'b1;
            state_nxt = ST_FCONV;
          end else begin
            req.value = {1'b0, ohms_sat};
            fred_nxt  = 1'b0;
            fshow_nxt = 1'b0;
            state_nxt = ST_OCONV;
          end
        end
      end
      ST_FCONV: begin
        if (rsp.done) begin
          fdig_nxt  = rsp.digits;
          req.start = 1'b1;
          state_nxt = ST_OCONV;
        end
      end
      ST_OCONV: begin
        if (rsp.done) begin
          odig_nxt  = rsp.digits;
          rnd_nxt   = rsp_count;
          rred_nxt  = rsp_count < rprev_r;
          rprev_nxt = rsp_count;
          cnt_nxt   = '0;
          if (fred_r) begin
            state_nxt = ST_FRED;
          end else if (fshow_r) begin
            state_nxt = ST_FDIG;
          end else if (rsp_count < rprev_r) begin
            state_nxt = ST_RRED;
          end else begin
            state_nxt = ST_RDIG;
          end
        end
      end
      ST_FRED: begin
        emit.valid = 1'b1;
        if (emit_ready) begin
          if (cnt_r == REDRAW_END) begin
            cnt_nxt   = '0;
            state_nxt = ST_FDIG;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_FDIG: begin
        emit.valid = 1'b1;
        emit.word  = digit_word(LINE1_ADDR, fnd_r, fdig_r, cnt_r[2:0]);
        if (emit_ready) begin
          if (cnt_r[2:0] == digit_end(fnd_r)) begin
            cnt_nxt   = '0;
            state_nxt = rred_r ? ST_RRED : ST_RDIG;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_RRED: begin
        emit.valid = 1'b1;
        if (emit_ready) begin
          if (cnt_r == REDRAW_END) begin
            cnt_nxt   = '0;
            state_nxt = ST_RDIG;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_RDIG: begin
        emit.valid = 1'b1;
        emit.word  = digit_word(LINE2_ADDR, rnd_r, odig_r, cnt_r[2:0]);
        emit.last  = (cnt_r[2:0] == digit_end(rnd_r));
        if (emit_ready) begin
          if (cnt_r[2:0] == digit_end(rnd_r)) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fprev_r <= 3'd3;
      rprev_r <= 3'd1;
      fshow_r <= 1'b0;
      fred_r  <= 1'b0;
      rred_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fprev_r <= fprev_nxt;
      rprev_r <= rprev_nxt;
      fshow_r <= fshow_nxt;
      fred_r  <= fred_nxt;
      rred_r  <= rred_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // payload of the item in work
  always_ff @(posedge clk) begin
    fnd_r  <= fnd_nxt;
    rnd_r  <= rnd_nxt;
    ohms_r <= ohms_nxt;
    fdig_r <= fdig_nxt;
    odig_r <= odig_nxt;
  end

endmodule

// ----- rtl/lcd_value_field_updater.sv -----
// flow: an input beat starts a binary to bcd conversion of the resistance, preceded by one of
// the frequency when it is shown (one 14-step conversion per value on a shared unit); then
// one output beat per cycle while out_tready allows, for the 2 to 46 instruction words of the
// run; the next input beat is taken only once the last word is in the output register
// reset: synchronous active low; digit counts return to 3 and 1, output register empties
module lcd_value_field_updater import lvf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // freq_value[25:0], ohms_value[38:26], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // lcd_word[9:0], zero pad
  output logic        out_tlast
);

  bcd_req_t          req;
  bcd_rsp_t          rsp;
  emit_t             emit;
  logic              emit_ready;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r;
  logic              out_last_r;

  lvf_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  lvf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .freq_value (in_tdata[FREQ_W-1:0]),
    .ohms_value (in_tdata[FREQ_W+OHMS_W-1:FREQ_W]),
    .req        (req),
    .rsp        (rsp),
    .emit       (emit),
    .emit_ready (emit_ready)
  );

  // output register, refilled in the cycle its beat is taken
  assign emit_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_ready) begin
      out_valid_nxt = emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit.valid) begin
      out_word_r <= emit.word;
      out_last_r <= emit.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_word_r};
  assign out_tlast  = out_last_r;

endmodule
